// ----- sv/qrs_pkg.sv -----
// shared widths, payload types and result codes for the quadratic root solver
`timescale 1ns / 1ps
package qrs_pkg;

  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned FRAC_BITS  = 16;

  // discriminant b*b - 4ac, signed, never clipped
  localparam int unsigned DW  = 2 * DATA_WIDTH + 2;
  // magnitude of the discriminant, even width for the two-bit root steps
  localparam int unsigned MW  = DW;
  // square root width
  localparam int unsigned SW  = MW / 2;
  // magnitude of -b +/- s
  localparam int unsigned NW  = DATA_WIDTH + 2;
  // scaled dividend magnitude, one quotient bit per step
  localparam int unsigned QW  = NW + FRAC_BITS;
  // divider stages: operand prep, one stage per quotient bit, saturation
  localparam int unsigned DIV_LAT = QW + 2;

  typedef enum logic [1:0] {
    KIND_TWO_REAL = 2'd0,
    KIND_REPEATED = 2'd1,
    KIND_COMPLEX  = 2'd2,
    KIND_A_ZERO   = 2'd3
  } kind_e;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] coef_a;
    logic signed [DATA_WIDTH-1:0] coef_b;
    logic signed [DATA_WIDTH-1:0] coef_c;
  } in_t;

  typedef struct packed {
    logic [1:0]                   root_kind;
    logic signed [DATA_WIDTH-1:0] first_value;
    logic signed [DATA_WIDTH-1:0] second_value;
    logic                         overflow;
  } out_t;

  // what rides along the square root pipeline
  typedef struct packed {
    kind_e                        kind;
    logic signed [DATA_WIDTH-1:0] coef_a;
    logic signed [DATA_WIDTH-1:0] coef_b;
  } sq_side_t;

endpackage

// ----- sv/quadratic_root_solver.sv -----
// SW + QW + 6 register stages after the transfer; every stage moves together on one enable
// throughput: one coefficient set per cycle while the output is not stalled
// the chain is two product/discriminant stages, one square root stage per root bit, a
// numerator stage, two dividers (prep, one stage per quotient bit, saturation) and output
// register; reset clears the valid bits only; data registers hold whatever they last took
`timescale 1ns / 1ps
module quadratic_root_solver (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  qrs_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output qrs_pkg::out_t  out_data_o
);

  localparam int unsigned W  = qrs_pkg::DATA_WIDTH;
  localparam int unsigned NW = qrs_pkg::NW;
  localparam int unsigned DL = qrs_pkg::DIV_LAT;

  // whole pipeline freezes only while a finished result is held back
  logic en;
  logic out_valid_q;
  qrs_pkg::out_t out_data_q;

  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  // discriminant front end
  logic                   disc_valid;
  logic [qrs_pkg::MW-1:0] disc_mag;
  qrs_pkg::sq_side_t      disc_side;

  qrs_disc u_disc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .valid_o (disc_valid),
    .mag_o   (disc_mag),
    .side_o  (disc_side)
  );

  // floor(sqrt(|d|)), exact in Q16.16 since d is Q32.32
  logic                   sq_valid;
  logic [qrs_pkg::SW-1:0] sq_root;
  qrs_pkg::sq_side_t      sq_side;

  qrs_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (disc_valid),
    .rad_i   (disc_mag),
    .side_i  (disc_side),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  // numerator stage: pick what each divider gets from the root kind
  logic signed [NW:0] neg_b;
  logic signed [NW:0] s_ext;
  logic signed [NW:0] num0_d;
  logic signed [NW:0] num1_d;

  logic signed [NW:0] num0_q;
  logic signed [NW:0] num1_q;
  logic signed [W:0]  den_q;
  logic               num_valid_q;
  qrs_pkg::kind_e     num_kind_q;

  always_comb begin
    neg_b = -((NW + 1)'(sq_side.coef_b));
    s_ext = $signed({2'b00, sq_root});
    if (sq_side.kind == qrs_pkg::KIND_COMPLEX) begin
      // real part -b/(2a), imaginary part s/(2a)
      num0_d = neg_b;
      num1_d = s_ext;
    end else begin
      // two real roots; a repeated root has s = 0 so both come out the same
      num0_d = neg_b + s_ext;
      num1_d = neg_b - s_ext;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_valid_q <= 1'b0;
    end else if (en) begin
      num_valid_q <= sq_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      num0_q     <= num0_d;
      num1_q     <= num1_d;
      den_q      <= (W + 1)'(sq_side.coef_a) <<< 1;
      num_kind_q <= sq_side.kind;
    end
  end

  // two dividers side by side, same latency
  logic signed [W-1:0] quot0;
  logic signed [W-1:0] quot1;
  logic                ovf0;
  logic                ovf1;

  qrs_div u_div0 (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  (num0_q),
    .den_i  (den_q),
    .quot_o (quot0),
    .ovf_o  (ovf0)
  );

  qrs_div u_div1 (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  (num1_q),
    .den_i  (den_q),
    .quot_o (quot1),
    .ovf_o  (ovf1)
  );

  // valid and kind travel beside the dividers
  logic           dl_valid_q[DL];
  qrs_pkg::kind_e dl_kind_q [DL];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DL; i++) begin
        dl_valid_q[i] <= 1'b0;
      end
    end else if (en) begin
      dl_valid_q[0] <= num_valid_q;
      for (int i = 1; i < DL; i++) begin
        dl_valid_q[i] <= dl_valid_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dl_kind_q[0] <= num_kind_q;
      for (int i = 1; i < DL; i++) begin
        dl_kind_q[i] <= dl_kind_q[i-1];
      end
    end
  end

  // output register; a zero a reports zeros and no overflow
  qrs_pkg::out_t out_d;

  always_comb begin
    out_d.root_kind = dl_kind_q[DL-1];
    if (dl_kind_q[DL-1] == qrs_pkg::KIND_A_ZERO) begin
      out_d.first_value  = '0;
      out_d.second_value = '0;
      out_d.overflow     = 1'b0;
    end else begin
      out_d.first_value  = quot0;
      out_d.second_value = quot1;
      out_d.overflow     = ovf0 | ovf1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dl_valid_q[DL-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ----- sv/qrs_disc.sv -----
// discriminant front end: products, then b*b - 4ac, root kind and magnitude
`timescale 1ns / 1ps
module qrs_disc (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  qrs_pkg::in_t                data_i,
  output logic                        valid_o,
  output logic [qrs_pkg::MW-1:0]      mag_o,
  output qrs_pkg::sq_side_t           side_o
);

  localparam int unsigned W = qrs_pkg::DATA_WIDTH;

  logic                       v1_q;
  logic signed [2*W-1:0]      ac_q;
  logic signed [2*W-1:0]      bb_q;
  logic signed [W-1:0]        a1_q;
  logic signed [W-1:0]        b1_q;
  logic                       a_zero_q;

  logic                       v2_q;
  logic [qrs_pkg::MW-1:0]     mag_q;
  qrs_pkg::sq_side_t          side_q;

  logic signed [qrs_pkg::DW-1:0] disc;
  qrs_pkg::kind_e                kind_d;
  logic [qrs_pkg::MW-1:0]        mag_d;

  // stage 1: the two products
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ac_q     <= (2*W)'(data_i.coef_a) * (2*W)'(data_i.coef_c);
      bb_q     <= (2*W)'(data_i.coef_b) * (2*W)'(data_i.coef_b);
      a1_q     <= data_i.coef_a;
      b1_q     <= data_i.coef_b;
      a_zero_q <= (data_i.coef_a == '0);
    end
  end

  // stage 2: discriminant sign and magnitude
  always_comb begin
    disc = qrs_pkg::DW'(bb_q) - (qrs_pkg::DW'(ac_q) <<< 2);
    mag_d = qrs_pkg::MW'(disc[qrs_pkg::DW-1] ? -disc : disc);
    if (a_zero_q) begin
      kind_d = qrs_pkg::KIND_A_ZERO;
    end else if (disc[qrs_pkg::DW-1]) begin
      kind_d = qrs_pkg::KIND_COMPLEX;
    end else if (disc == '0) begin
      kind_d = qrs_pkg::KIND_REPEATED;
    end else begin
      kind_d = qrs_pkg::KIND_TWO_REAL;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q         <= mag_d;
      side_q.kind   <= kind_d;
      side_q.coef_a <= a1_q;
      side_q.coef_b <= b1_q;
    end
  end

  assign valid_o = v2_q;
  assign mag_o   = mag_q;
  assign side_o  = side_q;

endmodule

// ----- sv/qrs_sqrt.sv -----
// pipelined integer square root, one result bit per stage
`timescale 1ns / 1ps
module qrs_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [qrs_pkg::MW-1:0]      rad_i,
  input  qrs_pkg::sq_side_t           side_i,
  output logic                        valid_o,
  output logic [qrs_pkg::SW-1:0]      root_o,
  output qrs_pkg::sq_side_t           side_o
);

  localparam int unsigned NS  = qrs_pkg::SW;
  localparam int unsigned RMW = qrs_pkg::SW + 2;

  logic [qrs_pkg::MW-1:0]  rad_q  [NS];
  logic [RMW-1:0]          rem_q  [NS];
  logic [qrs_pkg::SW-1:0]  root_q [NS];
  logic                    valid_q[NS];
  qrs_pkg::sq_side_t       side_q [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [qrs_pkg::MW-1:0] rad_in;
    logic [RMW-1:0]         rem_in;
    logic [qrs_pkg::SW-1:0] root_in;
    logic                   v_in;
    qrs_pkg::sq_side_t      side_in;
    logic [RMW-1:0]         rem_sh;
    logic [RMW-1:0]         trial;
    logic                   take;
    logic [RMW-1:0]         rem_d;
    logic [qrs_pkg::SW-1:0] root_d;

    if (k == 0) begin : g_first
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign v_in    = valid_i;
      assign side_in = side_i;
    end else begin : g_next
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign v_in    = valid_q[k-1];
      assign side_in = side_q[k-1];
    end

    // bring down the next two radicand bits, try (root << 2) | 1
    always_comb begin
      rem_sh = {rem_in[RMW-3:0], rad_in[qrs_pkg::MW-1 -: 2]};
      trial  = {root_in, 2'b01};
      take   = (rem_sh >= trial);
      rem_d  = take ? (rem_sh - trial) : rem_sh;
      root_d = {root_in[qrs_pkg::SW-2:0], take};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k]  <= rad_in << 2;
        rem_q[k]  <= rem_d;
        root_q[k] <= root_d;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = valid_q[NS-1];
  assign root_o  = root_q[NS-1];
  assign side_o  = side_q[NS-1];

endmodule

// ----- sv/qrs_div.sv -----
// pipelined signed Q divide (num << frac) / den, truncating, saturated to the data range
`timescale 1ns / 1ps
module qrs_div (
  input  logic                                    clk_i,
  input  logic                                    en_i,
  input  logic signed [qrs_pkg::NW:0]             num_i,
  input  logic signed [qrs_pkg::DATA_WIDTH:0]     den_i,
  output logic signed [qrs_pkg::DATA_WIDTH-1:0]   quot_o,
  output logic                                    ovf_o
);

  localparam int unsigned W  = qrs_pkg::DATA_WIDTH;
  localparam int unsigned QW = qrs_pkg::QW;

  logic [QW-1:0]  nq_p_q;
  logic [W:0]     dmag_p_q;
  logic           neg_p_q;

  logic [QW-1:0]  nq_q  [QW];
  logic [W:0]     rem_q [QW];
  logic [W:0]     dmag_q[QW];
  logic           neg_q [QW];

  logic signed [W-1:0] quot_q;
  logic                ovf_q;

  logic [qrs_pkg::NW-1:0] nmag;
  logic [W:0]             dmag;

  // operand prep: sign-magnitude, dividend scaled by the fraction bits
  always_comb begin
    nmag = qrs_pkg::NW'(num_i[qrs_pkg::NW] ? -num_i : num_i);
    dmag = den_i[W] ? -den_i : den_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nq_p_q   <= QW'(nmag) << qrs_pkg::FRAC_BITS;
      dmag_p_q <= dmag;
      neg_p_q  <= num_i[qrs_pkg::NW] ^ den_i[W];
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [QW-1:0] nq_in;
    logic [W:0]    rem_in;
    logic [W:0]    dmag_in;
    logic          neg_in;
    logic [W+1:0]  trial;
    logic          take;
    logic [W+1:0]  diff;

    if (k == 0) begin : g_first
      assign nq_in   = nq_p_q;
      assign rem_in  = '0;
      assign dmag_in = dmag_p_q;
      assign neg_in  = neg_p_q;
    end else begin : g_next
      assign nq_in   = nq_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign dmag_in = dmag_q[k-1];
      assign neg_in  = neg_q[k-1];
    end

    always_comb begin
      trial = {rem_in, nq_in[QW-1]};
      take  = (trial >= {1'b0, dmag_in});
      diff  = take ? (trial - {1'b0, dmag_in}) : trial;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nq_q[k]   <= {nq_in[QW-2:0], take};
        rem_q[k]  <= diff[W:0];
        dmag_q[k] <= dmag_in;
        neg_q[k]  <= neg_in;
      end
    end
  end

  // saturation to the signed data range
  logic [QW-1:0] qmag;
  logic          neg_f;
  logic          ovf_d;
  logic signed [W-1:0] quot_d;

  always_comb begin
    qmag  = nq_q[QW-1];
    neg_f = neg_q[QW-1];
    if (neg_f) begin
      ovf_d = (|qmag[QW-1:W]) || (qmag[W-1] && (|qmag[W-2:0]));
      quot_d = ovf_d ? {1'b1, {(W-1){1'b0}}} : -qmag[W-1:0];
    end else begin
      ovf_d = |qmag[QW-1:W-1];
      quot_d = ovf_d ? {1'b0, {(W-1){1'b1}}} : qmag[W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quot_q <= quot_d;
      ovf_q  <= ovf_d;
    end
  end

  assign quot_o = quot_q;
  assign ovf_o  = ovf_q;

endmodule

// ----- dv/qrs_checker.sv -----
// transfer monitor, root predictor and result comparison for the quadratic root solver
`timescale 1ns / 1ps
module qrs_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_stall_i,
  input  qrs_pkg::in_t  in_data_i,
  input  logic          out_valid_i,
  input  logic          out_stall_i,
  input  qrs_pkg::out_t out_data_i,
  output int unsigned   pending_o,
  output int unsigned   errors_o
);

  localparam longint VMAX = 64'sd2147483647;
  localparam longint VMIN = -64'sd2147483648;

  qrs_pkg::out_t roots_q[$];
  int unsigned mismatches;

  // floor of the square root of a 68-bit magnitude
  function automatic logic [67:0] root_floor(input logic [67:0] x);
    logic [67:0] res;
    logic [67:0] bits;
    res  = '0;
    bits = 68'd1 << 66;
    while (bits > x) bits = bits >> 2;
    while (bits != 0) begin
      if (x >= res + bits) begin
        x   = x - (res + bits);
        res = (res >> 1) + bits;
      end else begin
        res = res >> 1;
      end
      bits = bits >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [31:0] clip_quot(input longint num, input longint den,
                                                   inout logic ovf);
    longint q;
    q = (num * 64'sd65536) / den;
    if (q > VMAX) begin
      ovf = 1'b1;
      return VMAX[31:0];
    end
    if (q < VMIN) begin
      ovf = 1'b1;
      return VMIN[31:0];
    end
    return q[31:0];
  endfunction

  function automatic qrs_pkg::out_t solve_roots(input qrs_pkg::in_t c_in);
    qrs_pkg::out_t r;
    longint a, b, c, den, s;
    logic signed [67:0] disc;
    logic [67:0] mag;
    logic ovf;
    a   = c_in.coef_a;
    b   = c_in.coef_b;
    c   = c_in.coef_c;
    r   = '0;
    ovf = 1'b0;
    if (a == 0) begin
      r.root_kind = qrs_pkg::KIND_A_ZERO;
    end else begin
      disc = 68'(signed'(b)) * 68'(signed'(b)) - 68'sd4 * 68'(signed'(a)) * 68'(signed'(c));
      den  = 2 * a;
      mag  = disc < 0 ? 68'(-disc) : 68'(disc);
      s    = longint'(root_floor(mag));
      if (disc > 0) begin
        r.root_kind    = qrs_pkg::KIND_TWO_REAL;
        r.first_value  = clip_quot(-b + s, den, ovf);
        r.second_value = clip_quot(-b - s, den, ovf);
      end else if (disc == 0) begin
        r.root_kind    = qrs_pkg::KIND_REPEATED;
        r.first_value  = clip_quot(-b, den, ovf);
        r.second_value = r.first_value;
      end else begin
        r.root_kind    = qrs_pkg::KIND_COMPLEX;
        r.first_value  = clip_quot(-b, den, ovf);
        r.second_value = clip_quot(s, den, ovf);
      end
    end
    r.overflow = ovf;
    return r;
  endfunction

  assign pending_o = roots_q.size();
  assign errors_o  = mismatches;

  always @(posedge clk_i or negedge rst_ni) begin
    qrs_pkg::out_t want;
    if (!rst_ni) begin
      roots_q.delete();
      mismatches <= 0;
    end else begin
      // input transfer: predict now
      if (in_valid_i && !in_stall_i) roots_q.push_back(solve_roots(in_data_i));
      // output transfer: compare against oldest prediction
      if (out_valid_i && !out_stall_i) begin
        if (roots_q.size() == 0) begin
          if (mismatches < 10) $display("unexpected result %p", out_data_i);
          mismatches <= mismatches + 1;
        end else begin
          want = roots_q.pop_front();
          if (want.root_kind !== out_data_i.root_kind ||
              want.first_value !== out_data_i.first_value ||
              want.second_value !== out_data_i.second_value ||
              want.overflow !== out_data_i.overflow) begin
            if (mismatches < 10)
              $display({"mismatch: expected kind %0d v1 %0d v2 %0d ovf %0b,",
                        " got kind %0d v1 %0d v2 %0d ovf %0b"},
                       want.root_kind, want.first_value, want.second_value, want.overflow,
                       out_data_i.root_kind, out_data_i.first_value,
                       out_data_i.second_value, out_data_i.overflow);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end
endmodule

// ----- dv/quadratic_root_solver_tb.sv -----
// stimulus and verdict for the quadratic root solver testbench
`timescale 1ns / 1ps
module quadratic_root_solver_tb;

  localparam int unsigned LIMIT = 400000;
  localparam int unsigned LAT   = 89;

  logic clk_i;
  logic rst_ni;
  logic in_valid;
  logic in_stall;
  qrs_pkg::in_t  in_data;
  logic out_valid;
  logic out_stall = 1'b0;
  qrs_pkg::out_t out_data;

  int unsigned pending;
  int unsigned errors;
  int unsigned cycles = 0;
  // percent of cycles each side idles
  int unsigned send_idle;
  int unsigned recv_idle;

  quadratic_root_solver i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  qrs_checker i_chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // receiver back-pressure at the current idle rate
  always @(posedge clk_i) out_stall <= ($urandom_range(99) < recv_idle);

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // one transfer, then maybe an idle gap
  task automatic send_coefs(input logic [31:0] a, input logic [31:0] b, input logic [31:0] c);
    in_valid <= 1'b1;
    in_data  <= '{coef_a: a, coef_b: b, coef_c: c};
    do @(posedge clk_i); while (in_stall);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle);
    end
  endtask

  task automatic drain_roots();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // small signed value, within plus or minus 6 units in Q16.16
  function automatic logic [31:0] small_q();
    int v;
    v = $urandom_range(32'h000c_0000) - 32'h0006_0000;
    return v;
  endfunction

  task automatic send_random();
    int unsigned sel;
    int p, q;
    sel = $urandom_range(99);
    if (sel < 25) begin
      send_coefs($urandom, $urandom, $urandom);
    end else if (sel < 60) begin
      send_coefs(small_q(), small_q(), small_q());
    end else if (sel < 75) begin
      // perfect-square discriminant zero when 2pq fits in 32 bits: a=p*p, b=2pq, c=q*q
      p = $urandom_range(1, 40000) * ($urandom_range(1) ? 1 : -1);
      q = $urandom_range(0, 40000) * ($urandom_range(1) ? 1 : -1);
      send_coefs(p * p, 2 * p * q, q * q);
    end else if (sel < 82) begin
      send_coefs(32'd0, $urandom, $urandom);
    end else if (sel < 92) begin
      // tiny a pushes quotients out of range
      send_coefs($urandom_range(1, 4) * ($urandom_range(1) ? 1 : -1), $urandom, small_q());
    end else begin
      send_coefs(small_q(), $urandom, $urandom);
    end
  endtask

  initial begin
    rst_ni    = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    send_idle = 21;
    recv_idle = 85;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: zero a, extremes, repeated root, complex with negative a, overflow
    send_coefs(32'd0, 32'h8000_0000, 32'h7fff_ffff);
    send_coefs(32'd0, 32'd0, 32'd0);
    send_coefs(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_coefs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_coefs(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    send_coefs(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
    send_coefs(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_coefs(32'h0001_0000, 32'h0002_0000, 32'h0001_0000);
    send_coefs(32'h0001_0000, 32'hfffd_0000, 32'h0002_0000);
    send_coefs(32'h0001_0000, 32'h0000_0000, 32'h0001_0000);
    send_coefs(32'hffff_0000, 32'h0000_0000, 32'hffff_0000);
    send_coefs(32'hfffe_0000, 32'h0001_0000, 32'hfffd_0000);
    send_coefs(32'h0000_0001, 32'h7fff_ffff, 32'h0000_0000);
    send_coefs(32'hffff_ffff, 32'h8000_0000, 32'h0000_0001);
    send_coefs(32'h0000_0001, 32'h0000_0002, 32'h0000_0001);
    send_coefs(32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
    send_coefs(32'h0000_0001, 32'h0000_0003, 32'h0000_0002);
    send_coefs(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555);
    send_coefs(32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa);

    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        send_idle = 85;
        recv_idle = 21;
      end else if (ph == 2) begin
        send_idle = 0;
        recv_idle = 0;
      end
      for (int n = 0; n < 510; n++) send_random();
      // sender holds off until every root set is back
      drain_roots();
    end

    repeat (LAT + 20) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// ----- quadratic_root_solver.f -----
sv/qrs_pkg.sv
sv/qrs_disc.sv
sv/qrs_sqrt.sv
sv/qrs_div.sv
sv/quadratic_root_solver.sv
dv/qrs_checker.sv
dv/quadratic_root_solver_tb.sv
